// ----- hdl/nsf_pkg.sv -----
`timescale 1ns / 1ps

package nsf_pkg;

    // Default size of the sentence store in bytes
    localparam int MAX_SENTENCE_DEF = 512;

    // Entries in the queue between front and back; a power of two
    localparam int QUEUE_DEPTH = 4;

    localparam logic [9:0] MAX_LEN_RESET = 10'd512;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [1:0] STAT_NONE     = 2'd0;
    localparam logic [1:0] STAT_COMPLETE = 2'd1;
    localparam logic [1:0] STAT_DROPPED  = 2'd2;

    // Back-end operation codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [8:0] read_index;
    } t_in;

    typedef struct packed {
        logic [1:0] frame_status;
        logic [9:0] sentence_length;
        logic [7:0] read_data;
    } t_out;

    // Address-free part of one back-end command
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] wbyte;
        logic [1:0] status;
        logic [9:0] length;
    } t_cmd;

endpackage

// ----- hdl/nsf_front.sv -----
`timescale 1ns / 1ps

module nsf_front #(
    parameter int MAX_SENTENCE = nsf_pkg::MAX_SENTENCE_DEF,
    parameter int ADDR_W       = $clog2(MAX_SENTENCE)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [9:0]        i_cfg_wdata,
    input  logic              i_valid,
    input  nsf_pkg::t_in      i_data,
    input  logic              i_full,
    output logic              o_push,
    output nsf_pkg::t_cmd     o_cmd,
    output logic [ADDR_W-1:0] o_addr
);
    import nsf_pkg::*;

    localparam int FILL_W = $clog2(MAX_SENTENCE + 1);
    localparam int CMP_W  = (FILL_W + 1 > 10) ? FILL_W + 1 : 10;
    localparam int IDX_W  = ADDR_W + 9;

    logic [9:0]        r_max_len;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_in_sent, n_in_sent;
    logic              r_last_cr, n_last_cr;
    logic              r_too_long, n_too_long;

    logic [IDX_W-1:0]  idx_wide;
    logic              idx_ok;
    logic              room;
    logic [CMP_W-1:0]  total;
    logic              drop;

    assign o_push   = i_valid && !i_full;
    assign idx_wide = {{ADDR_W{1'b0}}, i_data.read_index};
    assign idx_ok   = idx_wide < IDX_W'(MAX_SENTENCE);
    assign room     = r_fill < FILL_W'(MAX_SENTENCE);
    assign total    = CMP_W'(r_fill) + CMP_W'(1);
    assign drop     = r_too_long || (total > CMP_W'(MAX_SENTENCE))
                   || (total > CMP_W'(r_max_len));

    always_comb begin
        n_fill     = r_fill;
        n_in_sent  = r_in_sent;
        n_last_cr  = r_last_cr;
        n_too_long = r_too_long;
        o_cmd      = '0;
        o_cmd.kind = CMD_NONE;
        o_addr     = '0;
        if (o_push) begin
            if (i_data.mode == MODE_READ) begin
                if (idx_ok) begin
                    o_cmd.kind = CMD_READ;
                    o_addr     = idx_wide[ADDR_W-1:0];
                end
            end else if (i_data.rx_byte == CH_DOLLAR) begin
                o_cmd.kind  = CMD_WRITE;
                o_cmd.wbyte = i_data.rx_byte;
                n_fill      = FILL_W'(1);
                n_in_sent   = 1'b1;
                n_last_cr   = 1'b0;
                n_too_long  = 1'b0;
            end else if (r_in_sent) begin
                if (room) begin
                    o_cmd.kind  = CMD_WRITE;
                    o_cmd.wbyte = i_data.rx_byte;
                    o_addr      = r_fill[ADDR_W-1:0];
                    n_fill      = r_fill + FILL_W'(1);
                end else begin
                    n_too_long = 1'b1;
                end
                if (r_last_cr && i_data.rx_byte == CH_LF) begin
                    if (drop) begin
                        o_cmd.status = STAT_DROPPED;
                    end else begin
                        o_cmd.status = STAT_COMPLETE;
                        o_cmd.length = total[9:0];
                    end
                    n_in_sent = 1'b0;
                    n_last_cr = 1'b0;
                end else begin
                    n_last_cr = (i_data.rx_byte == CH_CR);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= MAX_LEN_RESET;
            r_fill     <= '0;
            r_in_sent  <= 1'b0;
            r_last_cr  <= 1'b0;
            r_too_long <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            r_fill     <= n_fill;
            r_in_sent  <= n_in_sent;
            r_last_cr  <= n_last_cr;
            r_too_long <= n_too_long;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_SENTENCE))
        else $error("fill count beyond store size");

    a_dollar_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && i_data.mode == MODE_PUSH && i_data.rx_byte == CH_DOLLAR
        |=> r_fill == FILL_W'(1) && r_in_sent && !r_too_long)
        else $error("dollar did not open a sentence");

endmodule

// ----- hdl/nsf_queue.sv -----
`timescale 1ns / 1ps

module nsf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);
    import nsf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_rdata = r_slot[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("queue pushed when full or popped when empty");

    a_count_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop && !i_push |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("queue count did not drop on pop");

endmodule

// ----- hdl/nsf_back.sv -----
`timescale 1ns / 1ps

module nsf_back #(
    parameter int MAX_SENTENCE = nsf_pkg::MAX_SENTENCE_DEF,
    parameter int ADDR_W       = $clog2(MAX_SENTENCE)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  nsf_pkg::t_cmd     i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output nsf_pkg::t_out     o_data
);
    import nsf_pkg::*;

    logic [7:0]  r_mem [MAX_SENTENCE];
    logic [7:0]  r_rd;
    t_cmd        r_cmd;
    logic        r_valid;
    logic        advance;

    assign advance = !r_valid || !i_stall;
    assign o_pop   = i_q_valid && advance;
    assign o_valid = r_valid;

    always_comb begin
        o_data                 = '0;
        o_data.frame_status    = r_cmd.status;
        o_data.sentence_length = r_cmd.length;
        o_data.read_data       = (r_cmd.kind == CMD_READ) ? r_rd : 8'd0;
    end

    // Single-port store: at most one write or one read per command
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_cmd.kind == CMD_WRITE) begin
                r_mem[i_addr] <= i_cmd.wbyte;
            end
            if (i_cmd.kind == CMD_READ) begin
                r_rd <= r_mem[i_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_q_valid;
        end
    end

    a_status_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.frame_status != STAT_NONE |-> o_data.read_data == 8'd0)
        else $error("framing status and read data in one result");

    a_length_only_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.frame_status != STAT_COMPLETE |-> o_data.sentence_length == 10'd0)
        else $error("length reported without a complete sentence");

endmodule

// ----- hdl/nmea_sentence_framer_core.sv -----
`timescale 1ns / 1ps

// NMEA 0183 sentence framer. Push received bytes (mode 0) and the core cuts out
// sentences from the latest '$' through a CR LF pair; every push yields one
// result transaction, which at the LF reports either a complete sentence with
// its length or a drop when the sentence ran past max_sentence_length or the
// MAX_SENTENCE-byte store. A '$' always restarts the sentence; bytes outside an
// open sentence are ignored. Read the stored sentence back with mode 1 items
// (read_index past the store returns 0) before the next '$' overwrites it;
// reading a position never written since reset returns an undefined byte. Rate:
// one transaction per cycle sustained on both sides while the output is not
// stalled, set by the single-port sentence store, which takes at most one write
// or one read per item. An accepted item is held in the queue and then in the
// result register before its result turns valid.
// A four-entry queue between the framing front end and the store back end lets
// input keep flowing while the output is stalled, until the queue fills. Write
// max_sentence_length only while the core is idle.
module nmea_sentence_framer_core #(
    parameter int MAX_SENTENCE = nsf_pkg::MAX_SENTENCE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [9:0]    i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_stall,
    input  nsf_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output nsf_pkg::t_out o_data
);
    import nsf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SENTENCE);
    localparam int CMD_W  = $bits(t_cmd);
    localparam int Q_W    = CMD_W + ADDR_W;

    // Front end to queue
    logic              push;
    t_cmd              f_cmd;
    logic [ADDR_W-1:0] f_addr;
    logic              q_full;

    // Queue to back end
    logic              q_valid;
    logic              pop;
    logic [Q_W-1:0]    q_rdata;
    t_cmd              b_cmd;
    logic [ADDR_W-1:0] b_addr;

    // Stall input only on a full queue; never look at i_valid
    assign o_stall = q_full;

    assign b_cmd  = t_cmd'(q_rdata[Q_W-1:ADDR_W]);
    assign b_addr = q_rdata[ADDR_W-1:0];

    // Front: track sentence state and turn each item into a store command
    nsf_front #(
        .MAX_SENTENCE (MAX_SENTENCE),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .i_full      (q_full),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .o_addr      (f_addr)
    );

    // Decouple the two halves so each can stall on its own
    nsf_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_cmd, f_addr}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    // Back: apply commands to the store and hold the result transaction
    nsf_back #(
        .MAX_SENTENCE (MAX_SENTENCE),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (b_cmd),
        .i_addr    (b_addr),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule
